>>> hw/rtl/rv64_pkg.sv
// ----------------------------------------------------------------------------
// RV64IM execute package
// Shared widths, codes and types of the RV64IM execution block.
// ----------------------------------------------------------------------------
package rv64_pkg;

   localparam int XLEN          = 64;
   localparam int RF_DEPTH      = 32;
   localparam int MEM_BYTES_DEF = 65536;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 16;

   // Item kinds.
   localparam logic [1:0] KIND_EXEC    = 2'd0;
   localparam logic [1:0] KIND_RESTART = 2'd1;
   localparam logic [1:0] KIND_PRELOAD = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_BADADDR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SP    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GP    = 2'd2;

   // Registers loaded by a restart.
   localparam logic [4:0] REG_SP = 5'd2;
   localparam logic [4:0] REG_GP = 5'd3;

   // Major opcodes.
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_JAL    = 7'h6f;
   localparam logic [6:0] OP_IMMW   = 7'h1b;
   localparam logic [6:0] OP_LUI    = 7'h37;
   localparam logic [6:0] OP_AUIPC  = 7'h17;
   localparam logic [6:0] OP_REGW   = 7'h3b;

   // funct7 codes.
   localparam logic [6:0] F7_BASE = 7'd0;
   localparam logic [6:0] F7_ALT  = 7'd32;
   localparam logic [6:0] F7_MD   = 7'd1;

   // funct3 codes.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_MUL  = 3'd0;
   localparam logic [2:0] F3_MULH = 3'd1;
   localparam logic [2:0] F3_DIV  = 3'd4;
   localparam logic [2:0] F3_REM  = 3'd6;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_MAXLS = 3'd3;

   localparam logic [5:0] SRAI_TOP = 6'h10;

   typedef enum logic [1:0] {
      MD_MUL,
      MD_MULH,
      MD_DIV,
      MD_REM
   } md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_req_type;

endpackage

>>> hw/rtl/rv64_ram.sv
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rv64_ram #(
   parameter int WIDTH = rv64_pkg::XLEN,
   parameter int DEPTH = rv64_pkg::RF_DEPTH,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/rv64_muldiv.sv
// ----------------------------------------------------------------------------
// RV64 multiply and divide unit
// Multiplies with four 32x32 partial products and divides one bit per cycle.
// ----------------------------------------------------------------------------
module rv64_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  rv64_pkg::md_req_type md_req,
   input  logic [63:0]          op_a,
   input  logic [63:0]          op_b,
   output logic                 md_done,
   output logic [63:0]          md_result
);

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MULT,
      MD_CORR,
      MD_DIVI,
      MD_SIGN,
      MD_DONE
   } md_state_type;

   md_state_type        state_ff;
   rv64_pkg::md_op_type op_ff;
   logic [63:0]         a_ff;
   logic [63:0]         b_ff;
   logic                an_ff;
   logic                bn_ff;
   logic [5:0]          cnt_ff;
   logic [63:0]         pp_ff;
   logic [1:0]          psh_ff;
   logic [127:0]        acc_ff;
   logic [63:0]         q_ff;
   logic [63:0]         r_ff;
   logic [63:0]         result_ff;

   logic [31:0]  mul_a;
   logic [31:0]  mul_b;
   logic [63:0]  pp_w;
   logic [127:0] acc_add;
   logic [63:0]  hi_corr;
   logic [64:0]  rem_sh;
   logic [64:0]  rem_sub;

   assign mul_a   = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign mul_b   = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp_w    = mul_a * mul_b;
   assign acc_add = {64'd0, pp_ff} << {psh_ff, 5'd0};
   assign hi_corr = acc_ff[127:64] - (an_ff ? b_ff : 64'd0) - (bn_ff ? a_ff : 64'd0);
   assign rem_sh  = {r_ff, q_ff[63]};
   assign rem_sub = rem_sh - {1'b0, b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         unique case (state_ff)
            MD_IDLE: begin
               if (md_req.start) begin
                  op_ff  <= md_req.op;
                  a_ff   <= op_a;
                  an_ff  <= op_a[63];
                  bn_ff  <= op_b[63];
                  cnt_ff <= '0;
                  acc_ff <= '0;
                  r_ff   <= '0;
                  if (md_req.op == rv64_pkg::MD_MUL || md_req.op == rv64_pkg::MD_MULH) begin
                     b_ff     <= op_b;
                     state_ff <= MD_MULT;
                  end else if (op_b == 64'd0) begin
                     // Division by zero: all ones, or the dividend as remainder.
                     result_ff <= (md_req.op == rv64_pkg::MD_REM) ? op_a : '1;
                     state_ff  <= MD_DONE;
                  end else begin
                     b_ff     <= op_b[63] ? 64'd0 - op_b : op_b;
                     q_ff     <= op_a[63] ? 64'd0 - op_a : op_a;
                     state_ff <= MD_DIVI;
                  end
               end
            end
            MD_MULT: begin
               pp_ff  <= pp_w;
               psh_ff <= {1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]};
               if (cnt_ff != 6'd0) begin
                  acc_ff <= acc_ff + acc_add;
               end
               if (cnt_ff == 6'd4) begin
                  state_ff <= MD_CORR;
               end
               cnt_ff <= cnt_ff + 6'd1;
            end
            MD_CORR: begin
               result_ff <= (op_ff == rv64_pkg::MD_MULH) ? hi_corr : acc_ff[63:0];
               state_ff  <= MD_DONE;
            end
            MD_DIVI: begin
               if (!rem_sub[64]) begin
                  r_ff <= rem_sub[63:0];
                  q_ff <= {q_ff[62:0], 1'b1};
               end else begin
                  r_ff <= rem_sh[63:0];
                  q_ff <= {q_ff[62:0], 1'b0};
               end
               if (cnt_ff == 6'd63) begin
                  state_ff <= MD_SIGN;
               end
               cnt_ff <= cnt_ff + 6'd1;
            end
            MD_SIGN: begin
               if (op_ff == rv64_pkg::MD_REM) begin
                  result_ff <= an_ff ? 64'd0 - r_ff : r_ff;
               end else begin
                  result_ff <= (an_ff != bn_ff) ? 64'd0 - q_ff : q_ff;
               end
               state_ff <= MD_DONE;
            end
            MD_DONE: begin
               state_ff <= MD_IDLE;
            end
            default: begin
               state_ff <= MD_IDLE;
            end
         endcase
      end
   end

   assign md_done   = (state_ff == MD_DONE);
   assign md_result = result_ff;

endmodule

>>> hw/rtl/rv64im_instruction_execute.sv
// ----------------------------------------------------------------------------
// RV64IM instruction execute
// Executes one RV64IM instruction per item against its own registers,
// program counter and data memory, and returns one result item.
// ----------------------------------------------------------------------------
// An execute item goes through S_RS2, S_EXEC, then S_MEM for a load or
// store or S_MD for MUL/MULH and DIV/REM, which waits on the iterative
// multiply/divide unit, and S_DONE. Restart goes through S_RST and S_RST3,
// preload through S_PRE. One item is worked on at a time; the next is
// accepted once the result is in the output register. The register file is
// read through a single port, so the two source operands are read in turn.
// Reset clears the PC, marks all registers as zero and restores config
// defaults; the data memory is not cleared.
module rv64im_instruction_execute #(
   parameter int MEM_BYTES = rv64_pkg::MEM_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [rv64_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rv64_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_kind,
   input  logic [31:0]                        req_instruction,
   input  logic [12:0]                        req_preload_index,
   input  logic [63:0]                        req_preload_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [63:0]                        rsp_next_pc,
   output logic [4:0]                         rsp_dest_index,
   output logic                               rsp_dest_written,
   output logic signed [63:0]                 rsp_dest_value,
   output logic                               rsp_branch_taken,
   output logic [1:0]                         rsp_status
);

   localparam int DM_DEPTH = MEM_BYTES / 8;
   localparam int DM_AW    = $clog2(DM_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RS2,
      S_EXEC,
      S_MEM,
      S_MD,
      S_PRE,
      S_RST,
      S_RST3,
      S_DONE
   } state_type;

   function automatic logic [63:0] sx32(input logic [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   state_type    state_ff;
   logic [63:0]  pc_ff;
   logic [31:0]  rf_vld_ff;
   logic [15:0]  start_ff;
   logic [15:0]  sp_ff;
   logic [15:0]  gp_ff;

   // Latched item.
   logic [1:0]   kind_ff;
   logic [31:0]  instr_ff;
   logic [12:0]  pidx_ff;
   logic [63:0]  pdata_ff;

   // Operands and the pending result.
   logic [63:0]  a_ff;
   logic [63:0]  b_ff;
   logic [63:0]  ad_ff;
   logic         word_ff;
   logic [63:0]  res_npc_ff;
   logic [63:0]  res_val_ff;
   logic         res_wr_ff;
   logic         res_hasrd_ff;
   logic         res_taken_ff;
   logic [1:0]   res_status_ff;

   // Output register.
   logic         rsp_valid_ff;
   logic [63:0]  rsp_npc_ff;
   logic [4:0]   rsp_rd_ff;
   logic         rsp_wr_ff;
   logic [63:0]  rsp_val_ff;
   logic         rsp_taken_ff;
   logic [1:0]   rsp_status_ff;

   // Memory ports.
   logic             rf_we;
   logic [4:0]       rf_waddr;
   logic [63:0]      rf_wdata;
   logic [4:0]       rf_raddr;
   logic [63:0]      rf_rdata;
   logic             dm_we;
   logic [DM_AW-1:0] dm_waddr;
   logic [63:0]      dm_wdata;
   logic [DM_AW-1:0] dm_raddr;
   logic [63:0]      dm_rdata;

   rv64_pkg::md_req_type md_req;
   logic                 md_done;
   logic [63:0]          md_result;
   logic [63:0]          md_a;
   logic [63:0]          md_b;

   // Instruction fields.
   logic [6:0]   opc;
   logic [4:0]   rd;
   logic [2:0]   f3;
   logic [6:0]   f7;
   logic [63:0]  immi;
   logic [63:0]  imms;
   logic [63:0]  immb;
   logic [63:0]  immj;
   logic [63:0]  immu;
   logic [63:0]  b_w;
   logic [63:0]  pc4;

   // Execute results.
   logic [1:0]   ex_status;
   logic [63:0]  ex_val;
   logic         ex_wr;
   logic         ex_hasrd;
   logic         ex_taken;
   logic [63:0]  ex_npc;
   logic         ex_mem;
   logic         ex_md;
   logic         ex_word;
   rv64_pkg::md_op_type ex_md_op;
   logic [63:0]  ex_ad;
   logic [63:0]  ex_amask;

   logic         rsp_load;
   logic         fin_wr;
   logic         is_store;
   logic         pre_fits;
   logic [5:0]   byte_sh;
   logic [63:0]  ld_raw;
   logic [63:0]  ld_val;
   logic [63:0]  st_mask;
   logic [63:0]  st_data;

   assign opc  = instr_ff[6:0];
   assign rd   = instr_ff[11:7];
   assign f3   = instr_ff[14:12];
   assign f7   = instr_ff[31:25];
   assign immi = {{52{instr_ff[31]}}, instr_ff[31:20]};
   assign imms = {{52{instr_ff[31]}}, instr_ff[31:25], instr_ff[11:7]};
   assign immb = {{51{instr_ff[31]}}, instr_ff[31], instr_ff[7], instr_ff[30:25],
                  instr_ff[11:8], 1'b0};
   assign immj = {{43{instr_ff[31]}}, instr_ff[31], instr_ff[19:12], instr_ff[20],
                  instr_ff[30:21], 1'b0};
   assign immu = {{32{instr_ff[31]}}, instr_ff[31:12], 12'd0};
   assign pc4  = pc_ff + 64'd4;

   // Registers never written since the last reset or restart read as zero.
   assign b_w = rf_vld_ff[instr_ff[24:20]] ? rf_rdata : 64'd0;

   assign ex_ad    = a_ff + ((opc == rv64_pkg::OP_STORE) ? imms : immi);
   assign ex_amask = (64'd1 << f3[1:0]) - 64'd1;

   // Instruction decode and combinational execution.
   always_comb begin
      ex_status = rv64_pkg::ST_OK;
      ex_val    = '0;
      ex_wr     = 1'b1;
      ex_hasrd  = 1'b1;
      ex_taken  = 1'b0;
      ex_npc    = pc4;
      ex_mem    = 1'b0;
      ex_md     = 1'b0;
      ex_word   = 1'b0;
      ex_md_op  = rv64_pkg::MD_MUL;
      unique case (opc)
         rv64_pkg::OP_REG: begin
            if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_ADD) ex_val = a_ff + b_w;
            else if (f7 == rv64_pkg::F7_ALT && f3 == rv64_pkg::F3_ADD) ex_val = a_ff - b_w;
            else if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_SLL)
               ex_val = a_ff << b_w[5:0];
            else if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_SLT)
               ex_val = {63'd0, $signed(a_ff) < $signed(b_w)};
            else if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_XOR) ex_val = a_ff ^ b_w;
            else if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_SR)
               ex_val = a_ff >> b_w[5:0];
            else if (f7 == rv64_pkg::F7_ALT && f3 == rv64_pkg::F3_SR)
               ex_val = 64'($signed(a_ff) >>> b_w[5:0]);
            else if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_OR) ex_val = a_ff | b_w;
            else if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_AND) ex_val = a_ff & b_w;
            else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_MUL) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_MUL;
            end else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_MULH) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_MULH;
            end else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_DIV) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_DIV;
            end else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_REM) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_REM;
            end else ex_status = rv64_pkg::ST_ILLEGAL;
         end
         rv64_pkg::OP_IMM: begin
            if (f3 == rv64_pkg::F3_ADD) ex_val = a_ff + immi;
            else if (f3 == rv64_pkg::F3_SLL && instr_ff[31:26] == 6'd0)
               ex_val = a_ff << instr_ff[25:20];
            else if (f3 == rv64_pkg::F3_SLT)
               ex_val = {63'd0, $signed(a_ff) < $signed(immi)};
            else if (f3 == rv64_pkg::F3_XOR) ex_val = a_ff ^ immi;
            else if (f3 == rv64_pkg::F3_SR && instr_ff[31:26] == 6'd0)
               ex_val = a_ff >> instr_ff[25:20];
            else if (f3 == rv64_pkg::F3_SR && instr_ff[31:26] == rv64_pkg::SRAI_TOP)
               ex_val = 64'($signed(a_ff) >>> instr_ff[25:20]);
            else if (f3 == rv64_pkg::F3_OR) ex_val = a_ff | immi;
            else if (f3 == rv64_pkg::F3_AND) ex_val = a_ff & immi;
            else ex_status = rv64_pkg::ST_ILLEGAL;
         end
         rv64_pkg::OP_LOAD, rv64_pkg::OP_STORE: begin
            if (opc == rv64_pkg::OP_STORE) begin
               ex_wr    = 1'b0;
               ex_hasrd = 1'b0;
            end
            if (f3 > rv64_pkg::F3_MAXLS) ex_status = rv64_pkg::ST_ILLEGAL;
            else if ((ex_ad & ex_amask) != 64'd0 || ex_ad >= 64'(MEM_BYTES))
               ex_status = rv64_pkg::ST_BADADDR;
            else ex_mem = 1'b1;
         end
         rv64_pkg::OP_BRANCH: begin
            ex_wr    = 1'b0;
            ex_hasrd = 1'b0;
            case (f3)
               rv64_pkg::F3_BEQ: ex_taken = (a_ff == b_w);
               rv64_pkg::F3_BNE: ex_taken = (a_ff != b_w);
               rv64_pkg::F3_BLT: ex_taken = ($signed(a_ff) < $signed(b_w));
               rv64_pkg::F3_BGE: ex_taken = !($signed(a_ff) < $signed(b_w));
               default:          ex_status = rv64_pkg::ST_ILLEGAL;
            endcase
            if (ex_taken) ex_npc = pc_ff + immb;
         end
         rv64_pkg::OP_JALR: begin
            if (f3 != rv64_pkg::F3_ADD) ex_status = rv64_pkg::ST_ILLEGAL;
            else begin
               ex_val   = pc4;
               ex_npc   = (a_ff + immi) & ~64'd1;
               ex_taken = 1'b1;
            end
         end
         rv64_pkg::OP_JAL: begin
            ex_val   = pc4;
            ex_npc   = pc_ff + immj;
            ex_taken = 1'b1;
         end
         rv64_pkg::OP_IMMW: begin
            if (f3 == rv64_pkg::F3_ADD) ex_val = sx32(32'(a_ff + immi));
            else ex_status = rv64_pkg::ST_ILLEGAL;
         end
         rv64_pkg::OP_LUI:   ex_val = immu;
         rv64_pkg::OP_AUIPC: ex_val = pc_ff + immu;
         rv64_pkg::OP_REGW: begin
            ex_word = 1'b1;
            if (f7 == rv64_pkg::F7_BASE && f3 == rv64_pkg::F3_ADD)
               ex_val = sx32(32'(a_ff + b_w));
            else if (f7 == rv64_pkg::F7_ALT && f3 == rv64_pkg::F3_ADD)
               ex_val = sx32(32'(a_ff - b_w));
            else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_MUL) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_MUL;
            end else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_DIV) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_DIV;
            end else if (f7 == rv64_pkg::F7_MD && f3 == rv64_pkg::F3_REM) begin
               ex_md = 1'b1; ex_md_op = rv64_pkg::MD_REM;
            end else ex_status = rv64_pkg::ST_ILLEGAL;
         end
         default: ex_status = rv64_pkg::ST_ILLEGAL;
      endcase
      // A faulting instruction reports the current PC and changes nothing.
      if (ex_status != rv64_pkg::ST_OK) begin
         ex_val   = '0;
         ex_wr    = 1'b0;
         ex_hasrd = 1'b0;
         ex_taken = 1'b0;
         ex_npc   = pc_ff;
         ex_mem   = 1'b0;
         ex_md    = 1'b0;
      end
   end

   // Word forms multiply and divide the sign-extended low halves.
   assign md_a         = ex_word ? sx32(a_ff[31:0]) : a_ff;
   assign md_b         = ex_word ? sx32(b_w[31:0]) : b_w;
   assign md_req.start = (state_ff == S_EXEC) && ex_md;
   assign md_req.op    = ex_md_op;

   // Load extraction and store merge on the addressed doubleword.
   assign is_store = (opc == rv64_pkg::OP_STORE);
   assign byte_sh  = {ad_ff[2:0], 3'd0};
   assign ld_raw   = dm_rdata >> byte_sh;
   always_comb begin
      case (f3[1:0])
         2'd0:    ld_val = {{56{ld_raw[7]}}, ld_raw[7:0]};
         2'd1:    ld_val = {{48{ld_raw[15]}}, ld_raw[15:0]};
         2'd2:    ld_val = sx32(ld_raw[31:0]);
         default: ld_val = ld_raw;
      endcase
   end
   always_comb begin
      case (f3[1:0])
         2'd0:    st_mask = 64'hff;
         2'd1:    st_mask = 64'hffff;
         2'd2:    st_mask = 64'hffff_ffff;
         default: st_mask = '1;
      endcase
   end
   assign st_data = (dm_rdata & ~(st_mask << byte_sh)) |
                    ((b_ff << byte_sh) & (st_mask << byte_sh));

   assign pre_fits = 32'(pidx_ff) < 32'(DM_DEPTH);

   // Result hand-off: the output register loads when it is empty or drained.
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign fin_wr   = res_wr_ff && (rd != 5'd0);

   // Register file port control. Writes and reads never overlap in time
   // because one item is worked on at a time.
   assign rf_raddr = (state_ff == S_IDLE) ? req_instruction[19:15] : instr_ff[24:20];
   always_comb begin
      rf_we    = 1'b0;
      rf_waddr = rd;
      rf_wdata = res_val_ff;
      if (state_ff == S_RST) begin
         rf_we    = 1'b1;
         rf_waddr = rv64_pkg::REG_SP;
         rf_wdata = {48'd0, sp_ff};
      end else if (state_ff == S_RST3) begin
         rf_we    = 1'b1;
         rf_waddr = rv64_pkg::REG_GP;
         rf_wdata = {48'd0, gp_ff};
      end else if (rsp_load && fin_wr) begin
         rf_we = 1'b1;
      end
   end

   // Data memory port control.
   assign dm_raddr = ex_ad[DM_AW+2:3];
   always_comb begin
      dm_we    = 1'b0;
      dm_waddr = ad_ff[DM_AW+2:3];
      dm_wdata = st_data;
      if (state_ff == S_PRE) begin
         dm_we    = pre_fits;
         dm_waddr = DM_AW'(pidx_ff);
         dm_wdata = pdata_ff;
      end else if (state_ff == S_MEM) begin
         dm_we = is_store;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= '0;
         rf_vld_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 16'd0;
         sp_ff        <= 16'd32768;
         gp_ff        <= 16'd0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               rv64_pkg::CSR_START: start_ff <= csr_wdata;
               rv64_pkg::CSR_SP:    sp_ff    <= csr_wdata;
               rv64_pkg::CSR_GP:    gp_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff       <= req_kind;
                  instr_ff      <= req_instruction;
                  pidx_ff       <= req_preload_index;
                  pdata_ff      <= req_preload_data;
                  res_npc_ff    <= pc_ff;
                  res_val_ff    <= '0;
                  res_wr_ff     <= 1'b0;
                  res_hasrd_ff  <= 1'b0;
                  res_taken_ff  <= 1'b0;
                  res_status_ff <= rv64_pkg::ST_OK;
                  case (req_kind)
                     rv64_pkg::KIND_EXEC:    state_ff <= S_RS2;
                     rv64_pkg::KIND_RESTART: state_ff <= S_RST;
                     rv64_pkg::KIND_PRELOAD: state_ff <= S_PRE;
                     default:                state_ff <= S_DONE;
                  endcase
               end
            end
            S_RS2: begin
               a_ff     <= rf_vld_ff[instr_ff[19:15]] ? rf_rdata : 64'd0;
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               b_ff          <= b_w;
               ad_ff         <= ex_ad;
               word_ff       <= ex_word;
               res_npc_ff    <= ex_npc;
               res_val_ff    <= ex_val;
               res_wr_ff     <= ex_wr;
               res_hasrd_ff  <= ex_hasrd;
               res_taken_ff  <= ex_taken;
               res_status_ff <= ex_status;
               if (ex_md) state_ff <= S_MD;
               else if (ex_mem) state_ff <= S_MEM;
               else state_ff <= S_DONE;
            end
            S_MEM: begin
               if (!is_store) begin
                  res_val_ff <= ld_val;
               end
               state_ff <= S_DONE;
            end
            S_MD: begin
               if (md_done) begin
                  res_val_ff <= word_ff ? sx32(md_result[31:0]) : md_result;
                  state_ff   <= S_DONE;
               end
            end
            S_PRE: begin
               state_ff <= S_DONE;
            end
            S_RST: begin
               rf_vld_ff <= 32'd1 << rv64_pkg::REG_SP;
               state_ff  <= S_RST3;
            end
            S_RST3: begin
               rf_vld_ff[rv64_pkg::REG_GP] <= 1'b1;
               res_npc_ff <= {48'd0, start_ff};
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_npc_ff    <= res_npc_ff;
                  rsp_rd_ff     <= res_hasrd_ff ? rd : 5'd0;
                  rsp_wr_ff     <= fin_wr;
                  rsp_val_ff    <= fin_wr ? res_val_ff : 64'd0;
                  rsp_taken_ff  <= res_taken_ff;
                  rsp_status_ff <= res_status_ff;
                  pc_ff         <= res_npc_ff;
                  if (fin_wr) begin
                     rf_vld_ff[rd] <= 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   rv64_ram #(
      .WIDTH (rv64_pkg::XLEN),
      .DEPTH (rv64_pkg::RF_DEPTH)
   ) u_rf (
      .clock (clock),
      .we    (rf_we),
      .waddr (rf_waddr),
      .wdata (rf_wdata),
      .raddr (rf_raddr),
      .rdata (rf_rdata)
   );

   rv64_ram #(
      .WIDTH (rv64_pkg::XLEN),
      .DEPTH (DM_DEPTH)
   ) u_dm (
      .clock (clock),
      .we    (dm_we),
      .waddr (dm_waddr),
      .wdata (dm_wdata),
      .raddr (dm_raddr),
      .rdata (dm_rdata)
   );

   rv64_muldiv u_md (
      .clock     (clock),
      .reset     (reset),
      .md_req    (md_req),
      .op_a      (md_a),
      .op_b      (md_b),
      .md_done   (md_done),
      .md_result (md_result)
   );

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_next_pc      = rsp_npc_ff;
   assign rsp_dest_index   = rsp_rd_ff;
   assign rsp_dest_written = rsp_wr_ff;
   assign rsp_dest_value   = rsp_val_ff;
   assign rsp_branch_taken = rsp_taken_ff;
   assign rsp_status       = rsp_status_ff;

   // x0 must never be marked as holding a written value.
   a_x0_never_valid: assert property (@(posedge clock) disable iff (reset)
      !rf_vld_ff[0])
      else $error("x0 marked valid");

   // A reported register write never targets x0.
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_dest_written && rsp_dest_index == 5'd0))
      else $error("write to x0 reported");

   // A faulting item reports no write, no redirect and a zero value.
   a_fault_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rv64_pkg::ST_OK) |->
         (!rsp_dest_written && !rsp_branch_taken && rsp_dest_value == 64'sd0))
      else $error("faulting item changed state");

   // The multiply/divide unit only finishes while the sequencer waits for it.
   a_md_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      md_done |-> state_ff == S_MD)
      else $error("unexpected multiply/divide completion");

endmodule

>>> tb/rv64im_exec_checker.sv
// ----------------------------------------------------------------------------
// RV64IM execute checker
// Watches the request, result and config-write ports of the execute block,
// keeps its own copy of the architectural state, predicts one result per
// accepted item and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module rv64im_exec_checker
   import rv64_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [31:0]           req_instruction,
   input  logic [12:0]           req_preload_index,
   input  logic [63:0]           req_preload_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [63:0]           rsp_next_pc,
   input  logic [4:0]            rsp_dest_index,
   input  logic                  rsp_dest_written,
   input  logic signed [63:0]    rsp_dest_value,
   input  logic                  rsp_branch_taken,
   input  logic [1:0]            rsp_status,
   output int                    fail_count,
   output int                    pending,
   output int                    retired
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] MIN_INT = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] next_pc;
      logic [4:0]  dest_index;
      logic        dest_written;
      logic [63:0] dest_value;
      logic        branch_taken;
      logic [1:0]  status;
   } retire_type;

   logic [63:0] arch_regs [RF_DEPTH];
   logic [63:0] arch_pc;
   logic [7:0]  arch_mem [MEM_BYTES_DEF];
   logic [15:0] cfg_start;
   logic [15:0] cfg_sp;
   logic [15:0] cfg_gp;
   retire_type  expected_retires [$];

   assign pending = expected_retires.size();

   function automatic logic [63:0] sext(input logic [63:0] v, input int bits);
      logic [63:0] m;
      m = 64'd1 << (bits - 1);
      v = v & ((64'd1 << bits) - 1);
      return (v ^ m) - m;
   endfunction

   function automatic logic [63:0] div_rem(input logic [63:0] a, input logic [63:0] b,
                                           input logic want_rem);
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] q;
      logic [63:0] r;
      if (b == 64'd0) return want_rem ? a : '1;
      if (a == MIN_INT && b == '1) return want_rem ? 64'd0 : a;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      q = ua / ub;
      r = ua % ub;
      if (want_rem) return a[63] ? -r : r;
      return (a[63] ^ b[63]) ? -q : q;
   endfunction

   function automatic logic addr_fits(input logic [63:0] ad, input int size);
      return ((ad & (size - 1)) == 0) && (ad <= 64'(MEM_BYTES_DEF - size));
   endfunction

   // Applies one item to the shadow state and returns the result it produces.
   function automatic retire_type execute_item(input logic [1:0] kind,
                                               input logic [31:0] ins,
                                               input logic [12:0] pidx,
                                               input logic [63:0] pdata);
      retire_type  r;
      logic [6:0]  op;
      logic [6:0]  f7;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] immi;
      logic [63:0] val;
      logic [63:0] npc;
      logic [63:0] ad;
      logic [63:0] off;
      logic [127:0] prod;
      logic [5:0]  sh6;
      logic [5:0]  top6;
      logic [1:0]  status;
      logic        wr;
      logic        taken;
      logic        has_rd;
      int          size;
      op = ins[6:0];
      rd = ins[11:7];
      f3 = ins[14:12];
      f7 = ins[31:25];
      a = arch_regs[ins[19:15]];
      b = arch_regs[ins[24:20]];
      immi = sext(64'(ins[31:20]), 12);
      sh6 = ins[25:20];
      top6 = ins[31:26];
      val = '0;
      npc = arch_pc;
      status = ST_OK;
      wr = 1'b0;
      taken = 1'b0;
      has_rd = 1'b0;
      size = 1 << f3[1:0];
      if (kind == KIND_RESTART) begin
         foreach (arch_regs[i]) arch_regs[i] = '0;
         arch_regs[REG_SP] = 64'(cfg_sp);
         arch_regs[REG_GP] = 64'(cfg_gp);
         arch_pc = 64'(cfg_start);
         npc = arch_pc;
      end else if (kind == KIND_PRELOAD) begin
         if (64'(pidx) * 8 <= 64'(MEM_BYTES_DEF - 8))
            for (int i = 0; i < 8; i++) arch_mem[pidx * 8 + i] = pdata[8*i +: 8];
      end else if (kind == KIND_EXEC) begin
         npc = arch_pc + 4;
         has_rd = 1'b1;
         wr = 1'b1;
         case (op)
            OP_REG: begin
               if (f7 == F7_BASE && f3 == F3_ADD) val = a + b;
               else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
               else if (f7 == F7_BASE && f3 == F3_SLL) val = a << b[5:0];
               else if (f7 == F7_BASE && f3 == F3_SLT) val = 64'($signed(a) < $signed(b));
               else if (f7 == F7_BASE && f3 == F3_XOR) val = a ^ b;
               else if (f7 == F7_BASE && f3 == F3_SR) val = a >> b[5:0];
               else if (f7 == F7_ALT && f3 == F3_SR) val = $signed(a) >>> b[5:0];
               else if (f7 == F7_BASE && f3 == F3_OR) val = a | b;
               else if (f7 == F7_BASE && f3 == F3_AND) val = a & b;
               else if (f7 == F7_MD && f3 == F3_MUL) val = a * b;
               else if (f7 == F7_MD && f3 == F3_MULH) begin
                  // The low 128 bits of the sign-extended product are exact.
                  prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
                  val = prod[127:64];
               end
               else if (f7 == F7_MD && f3 == F3_DIV) val = div_rem(a, b, 1'b0);
               else if (f7 == F7_MD && f3 == F3_REM) val = div_rem(a, b, 1'b1);
               else status = ST_ILLEGAL;
            end
            OP_IMM: begin
               if (f3 == F3_ADD) val = a + immi;
               else if (f3 == F3_SLL && top6 == 6'd0) val = a << sh6;
               else if (f3 == F3_SLT) val = 64'($signed(a) < $signed(immi));
               else if (f3 == F3_XOR) val = a ^ immi;
               else if (f3 == F3_SR && top6 == 6'd0) val = a >> sh6;
               else if (f3 == F3_SR && top6 == SRAI_TOP) val = $signed(a) >>> sh6;
               else if (f3 == F3_OR) val = a | immi;
               else if (f3 == F3_AND) val = a & immi;
               else status = ST_ILLEGAL;
            end
            OP_LOAD: begin
               ad = a + immi;
               if (f3 > F3_MAXLS) status = ST_ILLEGAL;
               else if (!addr_fits(ad, size)) status = ST_BADADDR;
               else begin
                  for (int i = 0; i < size; i++) val[8*i +: 8] = arch_mem[ad + i];
                  if (size < 8) val = sext(val, 8 * size);
               end
            end
            OP_STORE: begin
               ad = a + sext(64'({ins[31:25], ins[11:7]}), 12);
               has_rd = 1'b0;
               wr = 1'b0;
               if (f3 > F3_MAXLS) status = ST_ILLEGAL;
               else if (!addr_fits(ad, size)) status = ST_BADADDR;
               else for (int i = 0; i < size; i++) arch_mem[ad + i] = b[8*i +: 8];
            end
            OP_BRANCH: begin
               off = sext(64'({ins[31], ins[7], ins[30:25], ins[11:8], 1'b0}), 13);
               has_rd = 1'b0;
               wr = 1'b0;
               if (f3 == F3_BEQ) taken = (a == b);
               else if (f3 == F3_BNE) taken = (a != b);
               else if (f3 == F3_BLT) taken = $signed(a) < $signed(b);
               else if (f3 == F3_BGE) taken = !($signed(a) < $signed(b));
               else status = ST_ILLEGAL;
               if (taken) npc = arch_pc + off;
            end
            OP_JALR: begin
               if (f3 != 3'd0) status = ST_ILLEGAL;
               else begin
                  val = arch_pc + 4;
                  npc = (a + immi) & ~64'd1;
                  taken = 1'b1;
               end
            end
            OP_JAL: begin
               off = sext(64'({ins[31], ins[19:12], ins[20], ins[30:21], 1'b0}), 21);
               val = arch_pc + 4;
               npc = arch_pc + off;
               taken = 1'b1;
            end
            OP_IMMW: begin
               if (f3 == F3_ADD) val = sext(a + immi, 32);
               else status = ST_ILLEGAL;
            end
            OP_LUI:   val = sext(64'({ins[31:12], 12'd0}), 32);
            OP_AUIPC: val = arch_pc + sext(64'({ins[31:12], 12'd0}), 32);
            OP_REGW: begin
               if (f7 == F7_BASE && f3 == F3_ADD) val = sext(a + b, 32);
               else if (f7 == F7_ALT && f3 == F3_ADD) val = sext(a - b, 32);
               else if (f7 == F7_MD && f3 == F3_MUL) val = sext(a * b, 32);
               else if (f7 == F7_MD && f3 == F3_DIV)
                  val = sext(div_rem(sext(a, 32), sext(b, 32), 1'b0), 32);
               else if (f7 == F7_MD && f3 == F3_REM)
                  val = sext(div_rem(sext(a, 32), sext(b, 32), 1'b1), 32);
               else status = ST_ILLEGAL;
            end
            default: status = ST_ILLEGAL;
         endcase
         if (status != ST_OK) begin
            // A rejected instruction leaves every piece of state alone.
            npc = arch_pc;
            wr = 1'b0;
            taken = 1'b0;
            has_rd = 1'b0;
            val = '0;
         end else begin
            if (wr && rd != 5'd0) arch_regs[rd] = val;
            else begin
               wr = 1'b0;
               val = '0;
            end
            arch_pc = npc;
         end
      end
      r.next_pc = npc;
      r.dest_index = has_rd ? rd : 5'd0;
      r.dest_written = wr;
      r.dest_value = val;
      r.branch_taken = taken;
      r.status = status;
      return r;
   endfunction

   initial begin
      foreach (arch_mem[i]) arch_mem[i] = '0;
      fail_count = 0;
      retired = 0;
   end

   always @(posedge clock) begin
      retire_type exp_r;
      if (reset) begin
         foreach (arch_regs[i]) arch_regs[i] <= '0;
         arch_pc <= '0;
         cfg_start <= 16'd0;
         cfg_sp <= 16'd32768;
         cfg_gp <= 16'd0;
         expected_retires.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START: cfg_start <= csr_wdata;
               CSR_SP:    cfg_sp <= csr_wdata;
               CSR_GP:    cfg_gp <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            retired++;
            if (expected_retires.size() == 0) begin
               $error("result with no item outstanding: next_pc %h", rsp_next_pc);
               fail_count++;
            end else begin
               exp_r = expected_retires.pop_front();
               if (rsp_next_pc !== exp_r.next_pc) begin
                  $error("next_pc expected %h actual %h", exp_r.next_pc, rsp_next_pc);
                  fail_count++;
               end
               if (rsp_dest_index !== exp_r.dest_index) begin
                  $error("dest_index expected %0d actual %0d",
                         exp_r.dest_index, rsp_dest_index);
                  fail_count++;
               end
               if (rsp_dest_written !== exp_r.dest_written) begin
                  $error("dest_written expected %b actual %b",
                         exp_r.dest_written, rsp_dest_written);
                  fail_count++;
               end
               if (rsp_dest_value !== exp_r.dest_value) begin
                  $error("dest_value expected %h actual %h",
                         exp_r.dest_value, rsp_dest_value);
                  fail_count++;
               end
               if (rsp_branch_taken !== exp_r.branch_taken) begin
                  $error("branch_taken expected %b actual %b",
                         exp_r.branch_taken, rsp_branch_taken);
                  fail_count++;
               end
               if (rsp_status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, rsp_status);
                  fail_count++;
               end
            end
         end
         // Config writes must come only while the block is idle, which it does
         // not enforce; the values seen here are those any accepted item uses.
         if (req_valid && req_ready)
            expected_retires.push_back(execute_item(req_kind, req_instruction,
                                                    req_preload_index, req_preload_data));
      end
   end

endmodule

>>> tb/tb_rv64im_instruction_execute.sv
// ----------------------------------------------------------------------------
// RV64IM instruction execute testbench
// Drives directed corner cases and weighted random instruction streams into
// the execute block under several register settings, with random stalls on
// both handshakes, and leaves the result checking to the checker module.
// ----------------------------------------------------------------------------
module tb_rv64im_instruction_execute;
   import rv64_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The fourth item kind is unused by the block; it must simply report the PC.
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 1500;
   localparam int PHASES = 4;
   localparam int IDLE_LIMIT = 20000;
   // Number of doublewords written up front so that loads inside the window
   // hit initialized memory.
   localparam int LOAD_WINDOW_DW = 16;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind = '0;
   logic [31:0]           req_instruction = '0;
   logic [12:0]           req_preload_index = '0;
   logic [63:0]           req_preload_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [63:0]           rsp_next_pc;
   logic [4:0]            rsp_dest_index;
   logic                  rsp_dest_written;
   logic signed [63:0]    rsp_dest_value;
   logic                  rsp_branch_taken;
   logic [1:0]            rsp_status;

   int fail_count;
   int pending;
   int retired;
   int items_sent = 0;
   int idle_cycles = 0;
   // Set by the stimulus once to ask the receiver for its long hold-off.
   bit hold_off_request = 1'b0;
   // When set, the sender offers items back to back.
   bit burst_mode = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   rv64im_instruction_execute dut (.*);

   rv64im_exec_checker checker_i (.*);

   // Short gaps dominate; a few long ones let the block drain completely.
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Most instructions work on the low registers so results feed each other.
   function automatic logic [4:0] pick_reg();
      if ($urandom_range(0, 9) < 7) return 5'($urandom_range(0, 7));
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] enc_s(input logic [11:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2,
                                         input logic [4:0] rs1, input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
   endfunction

   // Address offset, mostly in the preloaded window and naturally aligned.
   function automatic logic [11:0] window_offset(input logic [2:0] f3);
      int unsigned r;
      logic [11:0] off;
      r = $urandom_range(0, 9);
      off = 12'($urandom_range(0, LOAD_WINDOW_DW * 8 - 1));
      if (r < 8) return off & ~12'((1 << f3[1:0]) - 1);
      if (r < 9) return off;
      return 12'($urandom);
   endfunction

   // Weighted random instruction: every form, legal and illegal variants,
   // and a share of raw noise.
   function automatic logic [31:0] pick_instruction();
      int unsigned c;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [5:0]  top6;
      c = $urandom_range(0, 99);
      rd = pick_reg();
      rs1 = pick_reg();
      rs2 = pick_reg();
      f3 = 3'($urandom);
      case ($urandom_range(0, 5))
         0, 1, 2: f7 = F7_BASE;
         3, 4:    f7 = F7_ALT;
         default: f7 = 7'($urandom);
      endcase
      if (c < 18) return enc_r(f7, rs2, rs1, f3, rd, OP_REG);
      if (c < 32) begin
         case ($urandom_range(0, 3))
            0, 1:    top6 = 6'd0;
            2:       top6 = SRAI_TOP;
            default: top6 = 6'($urandom);
         endcase
         if (f3 == F3_SLL || f3 == F3_SR)
            return enc_i({top6, 6'($urandom)}, rs1, f3, rd, OP_IMM);
         return enc_i(12'($urandom), rs1, f3, rd, OP_IMM);
      end
      if (c < 38) begin
         if ($urandom_range(0, 4) != 0) f3 = F3_ADD;
         return enc_i(12'($urandom), rs1, f3, rd, OP_IMMW);
      end
      if (c < 44) begin
         if ($urandom_range(0, 3) != 0) f3 = ($urandom_range(0, 1) != 0) ? F3_ADD : F3_DIV;
         if ($urandom_range(0, 2) == 0) f7 = F7_MD;
         return enc_r(f7, rs2, rs1, f3, rd, OP_REGW);
      end
      if (c < 50) return {20'($urandom), rd, OP_LUI};
      if (c < 54) return {20'($urandom), rd, OP_AUIPC};
      if (c < 64) begin
         if ($urandom_range(0, 9) != 0) f3 = 3'($urandom_range(0, 3));
         // Loads only go through x0, so window offsets reach written memory.
         return enc_i(window_offset(f3), 5'd0, f3, rd, OP_LOAD);
      end
      if (c < 74) begin
         if ($urandom_range(0, 9) != 0) f3 = 3'($urandom_range(0, 3));
         if ($urandom_range(0, 4) != 0) return enc_s(window_offset(f3), rs2, 5'd0, f3);
         return enc_s(12'($urandom), rs2, rs1, f3);
      end
      if (c < 84) return enc_b(13'($urandom), rs2, rs1, f3);
      if (c < 88) return enc_j(21'($urandom), rd);
      if (c < 92) begin
         if ($urandom_range(0, 5) != 0) f3 = 3'd0;
         return enc_i(12'($urandom), rs1, f3, rd, OP_JALR);
      end
      if (c < 96) begin
         case ($urandom_range(0, 3))
            0:       f3 = F3_MUL;
            1:       f3 = F3_MULH;
            2:       f3 = F3_DIV;
            default: f3 = F3_REM;
         endcase
         return enc_r(F7_MD, rs2, rs1, f3, rd, OP_REG);
      end
      return $urandom;
   endfunction

   // Offers one item and returns at the clock edge where it is accepted.
   // Valid stays high on return so a back-to-back item follows with no gap.
   task automatic send_item(input logic [1:0] kind, input logic [31:0] ins,
                            input logic [12:0] pidx, input logic [63:0] pdata);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_instruction <= ins;
      req_preload_index <= pidx;
      req_preload_data <= pdata;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic exec(input logic [31:0] ins);
      send_item(KIND_EXEC, ins, 13'($urandom), {$urandom, $urandom});
   endtask

   // Must follow an accepted item directly: drops valid, then waits until
   // every accepted item has returned its result, plus a margin.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_config(input logic [15:0] start_pc, input logic [15:0] sp,
                               input logic [15:0] gp);
      csr_we <= 1'b1;
      csr_index <= CSR_START;
      csr_wdata <= start_pc;
      @(posedge clock);
      csr_index <= CSR_SP;
      csr_wdata <= sp;
      @(posedge clock);
      csr_index <= CSR_GP;
      csr_wdata <= gp;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Receiver: random stalls, quiet stretches, and one long hold-off on
   // request so the block backs up and holds off its input.
   initial begin
      int hold_left;
      int stall_left;
      int quiet_left;
      bit hold_done;
      hold_left = 0;
      stall_left = 0;
      quiet_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (quiet_left > 0) quiet_left--;
         else if ($urandom_range(0, 299) == 0) quiet_left = $urandom_range(50, 200);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (quiet_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
         end
      end
   end

   // Watchdog: any stretch with no handshake on either channel this long
   // means the block has hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_rv64im_instruction_execute: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned r;
      logic [15:0] cfg_start;
      logic [15:0] cfg_sp;
      logic [15:0] cfg_gp;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < PHASES; phase++) begin
         // Register settings: defaults, all ones, all zeros, then random.
         case (phase)
            0: begin cfg_start = 16'd0;     cfg_sp = 16'd32768;   cfg_gp = 16'd0;     end
            1: begin cfg_start = 16'hffff;  cfg_sp = 16'hffff;    cfg_gp = 16'hffff;  end
            2: begin cfg_start = 16'd0;     cfg_sp = 16'd0;       cfg_gp = 16'd0;     end
            default: begin
               cfg_start = 16'($urandom);
               cfg_sp = 16'($urandom);
               cfg_gp = 16'($urandom);
            end
         endcase
         write_config(cfg_start, cfg_sp, cfg_gp);
         send_item(KIND_RESTART, $urandom, 13'($urandom), {$urandom, $urandom});

         if (phase == 0) begin
            // Fill the load window so in-window loads read written memory.
            for (int i = 0; i < LOAD_WINDOW_DW; i++)
               send_item(KIND_PRELOAD, $urandom, 13'(i), {$urandom, $urandom});

            // Build the most negative value in x5, minus one in x6, and the
            // most negative word in x8.
            exec(enc_i(12'hfff, 5'd0, F3_ADD, 5'd6, OP_IMM));
            exec({20'h80000, 5'd5, OP_LUI});
            exec(enc_i({6'd0, 6'd32}, 5'd5, F3_SLL, 5'd5, OP_IMM));
            // Signed overflow at full and word width, zero divisors, and MULH.
            exec(enc_r(F7_MD, 5'd6, 5'd5, F3_DIV, 5'd7, OP_REG));
            exec(enc_r(F7_MD, 5'd6, 5'd5, F3_REM, 5'd7, OP_REG));
            exec(enc_r(F7_MD, 5'd0, 5'd6, F3_DIV, 5'd7, OP_REG));
            exec(enc_r(F7_MD, 5'd0, 5'd6, F3_REM, 5'd7, OP_REG));
            exec(enc_r(F7_MD, 5'd5, 5'd5, F3_MULH, 5'd7, OP_REG));
            exec({20'h80000, 5'd8, OP_LUI});
            exec(enc_r(F7_MD, 5'd6, 5'd8, F3_DIV, 5'd9, OP_REGW));
            exec(enc_r(F7_MD, 5'd6, 5'd8, F3_REM, 5'd9, OP_REGW));
            // Shift amount taken from the low six bits of minus one.
            exec(enc_r(F7_ALT, 5'd6, 5'd5, F3_SR, 5'd11, OP_REG));
            // Unsupported encodings: SLTU, LBU, BLTU, bad SLLI, JALR funct3.
            exec(enc_r(F7_BASE, 5'd6, 5'd5, 3'd3, 5'd7, OP_REG));
            exec(enc_i(12'd0, 5'd0, 3'd4, 5'd7, OP_LOAD));
            exec(enc_b(13'd8, 5'd6, 5'd5, 3'd6));
            exec(enc_i({6'h01, 6'd3}, 5'd5, F3_SLL, 5'd7, OP_IMM));
            exec(enc_i(12'd0, 5'd1, 3'd1, 5'd7, OP_JALR));
            send_item(KIND_UNUSED, $urandom, 13'($urandom), {$urandom, $urandom});
            // Misaligned word and a doubleword below address zero.
            exec(enc_i(12'd2, 5'd0, 3'd2, 5'd7, OP_LOAD));
            exec(enc_i(12'hff8, 5'd0, 3'd3, 5'd7, OP_LOAD));
            // Store and reload, x0 write, last preload index, branch and jump.
            exec(enc_s(12'd8, 5'd6, 5'd0, 3'd3));
            exec(enc_i(12'd8, 5'd0, 3'd3, 5'd10, OP_LOAD));
            exec(enc_i(12'd5, 5'd0, F3_ADD, 5'd0, OP_IMM));
            send_item(KIND_PRELOAD, $urandom, 13'h1fff, '1);
            exec(enc_b(13'd8, 5'd0, 5'd0, F3_BEQ));
            exec(enc_j(21'h0ffffe, 5'd1));
         end else begin
            // Each later phase restarts with the new settings; the window
            // stays written because memory survives a restart.
            exec(enc_i(12'($urandom), 5'd2, F3_ADD, 5'd12, OP_IMM));
         end

         for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
            if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (phase == 1 && n == 20) hold_off_request = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 90) exec(pick_instruction());
            else if (r < 92)
               send_item(KIND_PRELOAD, $urandom, 13'($urandom_range(0, LOAD_WINDOW_DW - 1)),
                         {$urandom, $urandom});
            else if (r < 94)
               send_item(KIND_PRELOAD, $urandom, 13'($urandom), {$urandom, $urandom});
            else if (r < 97)
               send_item(KIND_RESTART, $urandom, 13'($urandom), {$urandom, $urandom});
            else send_item(KIND_UNUSED, $urandom, 13'($urandom), {$urandom, $urandom});
         end
         burst_mode = 1'b0;
         drain();
      end

      $display("Ran %0d items over %0d register settings; %0d results checked.",
               items_sent, PHASES, retired);
      $display("Covered every instruction form, illegal and bad-address cases, %s",
               "restarts, preloads and a long result stall.");
      if (fail_count == 0) $display("tb_rv64im_instruction_execute: PASS");
      else $display("tb_rv64im_instruction_execute: FAIL");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/rv64_pkg.sv
hw/rtl/rv64_ram.sv
hw/rtl/rv64_muldiv.sv
hw/rtl/rv64im_instruction_execute.sv
tb/rv64im_exec_checker.sv
tb/tb_rv64im_instruction_execute.sv
